// ----- rtl/pwma_pkg.sv -----
// Package with the constants, payload types and codes of the weighted moving average block.
`timescale 1ns / 1ps
package pwma_pkg;

    localparam int HISTORY_DEPTH  = 16;
    localparam int CURSOR_SLOTS   = 8;
    localparam int QUEUE_DEPTH    = 2;
    localparam int POS_W          = 24;
    localparam int LEN_W          = 5;
    localparam int ID_W           = 16;
    localparam logic [LEN_W-1:0] HIST_LEN_RESET = LEN_W'(10);

    localparam int SLOT_W  = (CURSOR_SLOTS > 1) ? $clog2(CURSOR_SLOTS) : 1;
    localparam int PTR_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int WS_W    = $clog2(HISTORY_DEPTH * (HISTORY_DEPTH + 1) / 2 + 1);
    localparam int ACC_W   = POS_W + WS_W + 1;
    localparam int DCNT_W  = $clog2(ACC_W + 1);
    localparam int HIST_W  = 3 * POS_W;
    localparam int RAM_DEPTH = CURSOR_SLOTS * HISTORY_DEPTH;
    localparam int ADDR_W  = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
    localparam int QP_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_AVERAGED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_UNKNOWN  = 2'd2,
        ST_NO_SLOT  = 2'd3
    } t_status;

    typedef struct packed {
        logic                    command;
        logic [ID_W-1:0]         cursor_id;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_in;

    typedef struct packed {
        logic signed [POS_W-1:0] avg_x;
        logic signed [POS_W-1:0] avg_y;
        logic signed [POS_W-1:0] avg_z;
        logic [LEN_W-1:0]        samples_used;
        logic [1:0]              status;
    } t_out;

    typedef struct packed {
        t_status                 status;
        logic [SLOT_W-1:0]       slot;
        logic [PTR_W-1:0]        wr_ptr;
        logic [PTR_W-1:0]        rd_ptr;
        logic [CNT_W-1:0]        n;
        logic [WS_W-1:0]         wsum;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_job;

endpackage

// ----- rtl/pwma_ram.sv -----
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
module pwma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/pwma_fifo.sv -----
// Short job queue between the front and back parts.
`timescale 1ns / 1ps
module pwma_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pwma_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output pwma_pkg::t_job o_job
);
    import pwma_pkg::*;

    t_job             r_mem [QUEUE_DEPTH];
    logic [QP_W-1:0]  r_wp, r_rp;
    logic [QC_W-1:0]  r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == QC_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QC_W'(do_push) - QC_W'(do_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QC_W'(QUEUE_DEPTH))
        else $error("queue count exceeds its depth");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not grow on push");
    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("queue count did not shrink on pop");
endmodule

// ----- rtl/pwma_front.sv -----
// Front part: slot lookup, slot table update and job classification.
`timescale 1ns / 1ps
module pwma_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  pwma_pkg::t_in            i_item,
    input  logic [pwma_pkg::LEN_W-1:0] i_hist_len,
    input  logic                     i_full,
    output logic                     o_push,
    output pwma_pkg::t_job           o_job
);
    import pwma_pkg::*;

    logic              r_valid [CURSOR_SLOTS];
    logic [ID_W-1:0]   r_id    [CURSOR_SLOTS];
    logic [CNT_W-1:0]  r_count [CURSOR_SLOTS];
    logic [PTR_W-1:0]  r_wptr  [CURSOR_SLOTS];

    logic              hit, free_ok, take;
    logic [SLOT_W-1:0] hit_idx, free_idx, sel;
    logic [CNT_W-1:0]  eff_len, old_cnt, n_cnt;
    logic [CNT_W:0]    cnt1;
    logic [PTR_W-1:0]  old_wp, wp_new, rd_start;
    logic [PTR_W+1:0]  rd_tmp;

    always_comb begin
        hit      = 1'b0;
        free_ok  = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int s = 0; s < CURSOR_SLOTS; s++) begin
            if (r_valid[s] && r_id[s] == i_item.cursor_id && !hit) begin
                hit     = 1'b1;
                hit_idx = SLOT_W'(s);
            end
            if (!r_valid[s] && !free_ok) begin
                free_ok  = 1'b1;
                free_idx = SLOT_W'(s);
            end
        end
    end

    always_comb begin
        if (i_hist_len == '0) begin
            eff_len = CNT_W'(1);
        end else if (int'(i_hist_len) > HISTORY_DEPTH) begin
            eff_len = CNT_W'(HISTORY_DEPTH);
        end else begin
            eff_len = CNT_W'(i_hist_len);
        end
    end

    assign sel     = hit ? hit_idx : free_idx;
    assign old_cnt = hit ? r_count[sel] : '0;
    assign old_wp  = hit ? r_wptr[sel] : '0;
    assign cnt1    = {1'b0, old_cnt} + 1'b1;
    assign n_cnt   = (cnt1 > {1'b0, eff_len}) ? eff_len : cnt1[CNT_W-1:0];
    assign wp_new  = (old_wp == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : old_wp + 1'b1;
    assign rd_tmp  = (PTR_W+2)'(wp_new) + (PTR_W+2)'(HISTORY_DEPTH) - (PTR_W+2)'(n_cnt);
    assign rd_start = (rd_tmp >= (PTR_W+2)'(HISTORY_DEPTH))
                    ? PTR_W'(rd_tmp - (PTR_W+2)'(HISTORY_DEPTH)) : PTR_W'(rd_tmp);

    assign take   = i_valid && !i_full;
    assign o_push = take;

    always_comb begin
        o_job        = '0;
        o_job.slot   = sel;
        o_job.wr_ptr = old_wp;
        o_job.rd_ptr = rd_start;
        o_job.n      = n_cnt;
        o_job.wsum   = WS_W'((32'(n_cnt) * (32'(n_cnt) + 32'd1)) >> 1);
        o_job.pos_x  = i_item.pos_x;
        o_job.pos_y  = i_item.pos_y;
        o_job.pos_z  = i_item.pos_z;
        if (i_item.command == CMD_REMOVE) begin
            o_job.status = hit ? ST_REMOVED : ST_UNKNOWN;
        end else begin
            o_job.status = (hit || free_ok) ? ST_AVERAGED : ST_NO_SLOT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < CURSOR_SLOTS; s++) begin
                r_valid[s] <= 1'b0;
                r_id[s]    <= '0;
                r_count[s] <= '0;
                r_wptr[s]  <= '0;
            end
        end else if (take) begin
            if (i_item.command == CMD_REMOVE) begin
                if (hit) begin
                    r_valid[hit_idx] <= 1'b0;
                end
            end else if (hit || free_ok) begin
                r_valid[sel] <= 1'b1;
                r_id[sel]    <= i_item.cursor_id;
                r_count[sel] <= n_cnt;
                r_wptr[sel]  <= wp_new;
            end
        end
    end
endmodule

// ----- rtl/pwma_back.sv -----
// Back part: history write, weighted accumulation, division and result register.
`timescale 1ns / 1ps
module pwma_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  pwma_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output pwma_pkg::t_out o_out
);
    import pwma_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_WRITE = 7'b0000010,
        S_READ  = 7'b0000100,
        S_DRAIN = 7'b0001000,
        S_PREP  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state            r_state;
    t_job              r_job;
    logic [CNT_W-1:0]  r_k, r_pw;
    logic [PTR_W-1:0]  r_rp;
    logic              r_pv;
    logic signed [ACC_W-1:0] r_acc [3];
    logic [ACC_W-1:0]  r_quo [3];
    logic [WS_W-1:0]   r_rem [3];
    logic              r_neg [3];
    logic [DCNT_W-1:0] r_dcnt;
    logic              r_out_valid;
    t_out              r_out;
    t_out              n_out;

    logic              ram_we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [HIST_W-1:0] wdata, rdata;
    logic signed [POS_W-1:0] rd_pos [3];
    logic out_free;

    assign wdata  = {r_job.pos_x, r_job.pos_y, r_job.pos_z};
    assign ram_we = (r_state == S_WRITE);
    assign waddr  = ADDR_W'(int'(r_job.slot) * HISTORY_DEPTH + int'(r_job.wr_ptr));
    assign raddr  = ADDR_W'(int'(r_job.slot) * HISTORY_DEPTH + int'(r_rp));
    assign rd_pos[0] = rdata[3*POS_W-1:2*POS_W];
    assign rd_pos[1] = rdata[2*POS_W-1:POS_W];
    assign rd_pos[2] = rdata[POS_W-1:0];

    pwma_ram #(.WIDTH(HIST_W), .DEPTH(RAM_DEPTH)) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_valid  = r_out_valid;
    assign o_out    = r_out;

    // Result of the current job; the averages are only filled in for averaging jobs.
    always_comb begin
        n_out        = '0;
        n_out.status = r_job.status;
        if (r_job.status == ST_AVERAGED) begin
            n_out.samples_used = LEN_W'(r_job.n);
            n_out.avg_x = POS_W'(r_neg[0] ? -r_quo[0] : r_quo[0]);
            n_out.avg_y = POS_W'(r_neg[1] ? -r_quo[1] : r_quo[1]);
            n_out.avg_z = POS_W'(r_neg[2] ? -r_quo[2] : r_quo[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == S_WRITE) begin
            r_k  <= '0;
            r_rp <= r_job.rd_ptr;
            for (int a = 0; a < 3; a++) begin
                r_acc[a] <= '0;
            end
        end
        if (r_state == S_READ) begin
            r_k  <= r_k + 1'b1;
            r_pw <= r_k + 1'b1;
            r_rp <= (r_rp == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (r_pv) begin
            for (int a = 0; a < 3; a++) begin
                r_acc[a] <= r_acc[a] + ACC_W'(rd_pos[a] * $signed({1'b0, r_pw}));
            end
        end
        if (r_state == S_PREP) begin
            r_dcnt <= DCNT_W'(ACC_W);
            for (int a = 0; a < 3; a++) begin
                r_neg[a] <= r_acc[a][ACC_W-1];
                r_quo[a] <= r_acc[a][ACC_W-1] ? ACC_W'(-r_acc[a]) : ACC_W'(r_acc[a]);
                r_rem[a] <= '0;
            end
        end
        if (r_state == S_DIV) begin
            r_dcnt <= r_dcnt - 1'b1;
            for (int a = 0; a < 3; a++) begin
                if ({r_rem[a], r_quo[a][ACC_W-1]} >= {1'b0, r_job.wsum}) begin
                    r_rem[a] <= WS_W'({r_rem[a], r_quo[a][ACC_W-1]} - {1'b0, r_job.wsum});
                    r_quo[a] <= {r_quo[a][ACC_W-2:0], 1'b1};
                end else begin
                    r_rem[a] <= {r_rem[a][WS_W-2:0], r_quo[a][ACC_W-1]};
                    r_quo[a] <= {r_quo[a][ACC_W-2:0], 1'b0};
                end
            end
        end
        if (r_state == S_OUT && out_free) begin
            r_out <= n_out;
        end

        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pv <= (r_state == S_READ);
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_state <= (i_job.status == ST_AVERAGED) ? S_WRITE : S_OUT;
                    end
                end
                S_WRITE: r_state <= S_READ;
                S_READ: begin
                    if (r_k == r_job.n - 1'b1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: r_state <= S_PREP;
                S_PREP:  r_state <= S_DIV;
                S_DIV: begin
                    if (r_dcnt == DCNT_W'(1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_k < r_job.n))
        else $error("history read beyond the sample count");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dcnt != '0))
        else $error("divider ran past its last step");
    a_avg_has_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (r_job.n != '0 && r_job.wsum != '0))
        else $error("averaging job without samples");
endmodule

// ----- rtl/per_id_weighted_moving_average_top.sv -----
// Top level of the per-cursor linearly weighted moving average block.
`timescale 1ns / 1ps
// Each input transaction either adds a signed Q15.8 3-D position to the
// history of its cursor id and returns the linearly weighted mean of the
// newest samples (oldest weight 1, newest weight n, truncated toward zero),
// or removes that cursor's history. Eight cursor slots with sixteen history
// entries each are kept; a new id with no free slot is reported with status 3.
// The front part looks up the slot and updates the slot tables in the cycle a
// transaction is accepted, then hands a job to a two-entry queue, so input
// transactions are taken one per cycle until the queue is full. The back part
// owns the history RAM: an averaging job passes through a pop, a write, n
// history reads through the RAM's single read port, a drain and a prepare
// step, a 33-step bit-per-cycle division done for all three axes together,
// and an output step; remove and no-slot jobs go from the pop straight to the
// output step. The back part's job time sets the sustained rate. The output
// register holds a finished result while the consumer stalls, and the back
// part keeps working on the next job meanwhile, up to its output step.
// history_len is to be written over its own valid/ready channel only while the
// block is idle; the block does not enforce this. 0 acts as 1, above 16 as 16.
module per_id_weighted_moving_average_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  pwma_pkg::t_in              i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output pwma_pkg::t_out             o_out,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [pwma_pkg::LEN_W-1:0] i_cfg_data
);
    import pwma_pkg::*;

    logic [LEN_W-1:0] r_hist_len;
    logic             q_full, q_empty, q_push, q_pop;
    t_job             front_job, back_job;

    // The configuration register is always writable.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_len <= HIST_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_hist_len <= i_cfg_data;
        end
    end

    // Input transactions stall only when the job queue is full.
    assign o_in_stall = q_full;

    pwma_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_item     (i_in),
        .i_hist_len (r_hist_len),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_job      (front_job)
    );

    pwma_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (back_job)
    );

    pwma_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_job   (back_job),
        .o_pop   (q_pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_out   (o_out)
    );
endmodule

// ----- tb/pwma_checker.sv -----
// Checker that predicts and compares the results of the weighted moving average block.
`timescale 1ns / 1ps
module pwma_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  pwma_pkg::t_in              i_in,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  pwma_pkg::t_out             i_out,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [pwma_pkg::LEN_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    import pwma_pkg::*;

    localparam int EXP_DEPTH = 64;

    logic [LEN_W-1:0]         hist_len;
    logic                     trk_valid [CURSOR_SLOTS];
    logic [ID_W-1:0]          trk_id    [CURSOR_SLOTS];
    int                       trk_count [CURSOR_SLOTS];
    int                       trk_wp    [CURSOR_SLOTS];
    logic signed [POS_W-1:0]  hist_pos  [CURSOR_SLOTS][HISTORY_DEPTH][3];
    // Expected results in order, kept in a ring buffer.
    t_out                     exp_buf [EXP_DEPTH];
    int                       exp_head;
    int                       exp_tail;
    int                       exp_count;

    assign o_pending = exp_count;

    function automatic t_out predict_average(t_in item);
        t_out r;
        int hit, free_s, len, n, wp, p;
        longint acc [3];
        longint wsum;
        hit = -1;
        free_s = -1;
        r = '0;
        for (int s = 0; s < CURSOR_SLOTS; s++) begin
            if (trk_valid[s] && trk_id[s] == item.cursor_id && hit < 0) hit = s;
            if (!trk_valid[s] && free_s < 0) free_s = s;
        end
        if (item.command == CMD_REMOVE) begin
            if (hit < 0) begin
                r.status = ST_UNKNOWN;
            end else begin
                trk_valid[hit] = 1'b0;
                r.status = ST_REMOVED;
            end
            return r;
        end
        if (hit < 0) begin
            if (free_s < 0) begin
                r.status = ST_NO_SLOT;
                return r;
            end
            hit = free_s;
            trk_valid[hit] = 1'b1;
            trk_id[hit] = item.cursor_id;
            trk_count[hit] = 0;
            trk_wp[hit] = 0;
        end
        wp = trk_wp[hit];
        hist_pos[hit][wp][0] = item.pos_x;
        hist_pos[hit][wp][1] = item.pos_y;
        hist_pos[hit][wp][2] = item.pos_z;
        wp = (wp + 1) % HISTORY_DEPTH;
        trk_wp[hit] = wp;
        len = (hist_len == 0) ? 1 : (hist_len > HISTORY_DEPTH ? HISTORY_DEPTH : int'(hist_len));
        n = trk_count[hit] + 1;
        if (n > len) n = len;
        trk_count[hit] = n;
        acc = '{0, 0, 0};
        wsum = 0;
        for (int k = 0; k < n; k++) begin
            p = (wp + 2 * HISTORY_DEPTH - n + k) % HISTORY_DEPTH;
            for (int a = 0; a < 3; a++) acc[a] += longint'(hist_pos[hit][p][a]) * (k + 1);
            wsum += k + 1;
        end
        // SystemVerilog division truncates toward zero, as required.
        r.avg_x = POS_W'(acc[0] / wsum);
        r.avg_y = POS_W'(acc[1] / wsum);
        r.avg_z = POS_W'(acc[2] / wsum);
        r.samples_used = LEN_W'(n);
        r.status = ST_AVERAGED;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        int   errs;
        errs = 0;
        if (!i_rst_n) begin
            hist_len <= HIST_LEN_RESET;
            for (int s = 0; s < CURSOR_SLOTS; s++) begin
                trk_valid[s] = 1'b0;
                trk_count[s] = 0;
                trk_wp[s] = 0;
            end
            exp_head = 0;
            exp_tail = 0;
            exp_count = 0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) hist_len <= i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (exp_count == 0) begin
                    $display("%0t: unexpected result, expected none actual %p", $time, i_out);
                    errs++;
                end else begin
                    want = exp_buf[exp_head];
                    exp_head = (exp_head + 1) % EXP_DEPTH;
                    exp_count--;
                    if (want !== i_out) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, i_out);
                        errs++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (exp_count == EXP_DEPTH) begin
                    $display("%0t: too many results outstanding, expected at most %0d actual %0d",
                             $time, EXP_DEPTH, exp_count + 1);
                    errs++;
                end else begin
                    exp_buf[exp_tail] = predict_average(i_in);
                    exp_tail = (exp_tail + 1) % EXP_DEPTH;
                    exp_count++;
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end
endmodule

// ----- tb/tb_per_id_weighted_moving_average_top.sv -----
// Testbench top that drives the weighted moving average block and gives the verdict.
`timescale 1ns / 1ps
module tb_per_id_weighted_moving_average_top;
    import pwma_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    t_in              in_item;
    logic             out_valid;
    logic             out_stall;
    t_out             out_item;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_data;
    int               fail_count;
    int               pending;

    // Idling percentages for the sender and the receiver in the current phase.
    int               send_idle_pct;
    int               recv_stall_pct;
    // When set, the receiver holds stall high regardless of the percentage.
    logic             hold_off;

    per_id_weighted_moving_average_top dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out(out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    pwma_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out(out_item),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The receiver decides its stall afresh on every edge.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offer one transaction and hold it until it is accepted. The sender may idle first.
    // Valid stays high afterwards; the caller drops it when a sequence ends.
    task automatic send_item(input t_in item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    function automatic t_in make_item(logic cmd, logic [ID_W-1:0] id,
                                      logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                      logic [POS_W-1:0] z);
        t_in it;
        it.command = cmd;
        it.cursor_id = id;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        return it;
    endfunction

    function automatic logic [POS_W-1:0] rand_pos();
        case ($urandom_range(5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return POS_W'($urandom_range(0, 2000)) - 24'd1000;
            default: return POS_W'($urandom);
        endcase
    endfunction

    // Wait until every expected result has arrived, then let the back part settle.
    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_len(input logic [LEN_W-1:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic: a small pool of ids keeps histories long, while occasional
    // fresh ids and removes exercise slot claiming and exhaustion.
    task automatic random_phase(input int count);
        logic [ID_W-1:0] id;
        logic            cmd;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0:       id = ID_W'($urandom);
                1:       id = 16'hFFFF;
                default: id = ID_W'($urandom_range(0, 10));
            endcase
            cmd = ($urandom_range(9) == 0) ? CMD_REMOVE : CMD_SAMPLE;
            send_item(make_item(cmd, id, rand_pos(), rand_pos(), rand_pos()));
        end
        in_valid <= 1'b0;
    endtask

    initial begin
        int hold_cycles;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset length: extremes, removes, unknown id and a full table.
        send_item(make_item(CMD_SAMPLE, 16'h0000, 24'h7FFFFF, 24'h800000, 24'h000000));
        send_item(make_item(CMD_SAMPLE, 16'h0000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF));
        send_item(make_item(CMD_SAMPLE, 16'h0000, 24'h800000, 24'h7FFFFF, 24'h000001));
        send_item(make_item(CMD_REMOVE, 16'h0000, '0, '0, '0));
        send_item(make_item(CMD_REMOVE, 16'h0000, '0, '0, '0));
        send_item(make_item(CMD_REMOVE, 16'hFFFF, '1, '1, '1));
        for (int s = 0; s < CURSOR_SLOTS; s++)
            send_item(make_item(CMD_SAMPLE, ID_W'(16'hFFF0 + s), 24'hFFFFFD, 24'h3, 24'h0));
        // Every slot is taken, so a new id is refused.
        send_item(make_item(CMD_SAMPLE, 16'h1234, 24'h1, 24'h1, 24'h1));
        send_item(make_item(CMD_REMOVE, 16'hFFF3, '0, '0, '0));
        send_item(make_item(CMD_SAMPLE, 16'h1234, 24'h100, 24'hFFFF00, 24'h0));
        for (int s = 0; s < CURSOR_SLOTS; s++)
            send_item(make_item(CMD_REMOVE, ID_W'(16'hFFF0 + s), '0, '0, '0));
        send_item(make_item(CMD_REMOVE, 16'h1234, '0, '0, '0));
        in_valid <= 1'b0;
        drain();

        // Phases over several history lengths (0 and out-of-range included) and idling mixes.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_len(5'd16);
                1: write_len(5'd0);
                2: write_len(5'd1);
                3: write_len(5'd31);
                4: write_len(5'd3);
                5: write_len(5'd17);
                6: write_len(5'd10);
                default: write_len(5'd2);
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            if (ph == 2) begin
                // Long receiver hold-off while the sender keeps offering.
                fork
                    begin
                        hold_off = 1'b1;
                        hold_cycles = 0;
                        while (hold_cycles < 400) begin
                            @(posedge clk);
                            hold_cycles++;
                        end
                        hold_off = 1'b0;
                    end
                    random_phase(200);
                join
            end else begin
                random_phase(200);
            end
            drain();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
